// ===== hw/rtl/table_linear_interpolator_top_defines.svh =====
// Assertion macros shared by the interpolator checker.
`ifndef TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TLI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TLI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tli_pkg.sv =====
// Shared types, codes and constants of the table interpolator.
`default_nettype none

package tli_pkg;

	localparam int DATA_W         = 32;
	localparam int IN_IDX_W       = 5;
	localparam int NUM_POINTS_DEF = 32;
	localparam int ENTRY_W        = 2 * DATA_W;

	// Command codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Clamp values for the result
	localparam logic signed [DATA_W-1:0] SAT_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] SAT_MIN   = 32'sh8000_0000;
	localparam logic        [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic                     command;
		logic [IN_IDX_W-1:0]      point_index;
		logic signed [DATA_W-1:0] x_value;
		logic signed [DATA_W-1:0] y_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] y_result;
		logic                     saturated;
	} out_item_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [DATA_W-1:0] quo;
	} div_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDR,
		S_CMP,
		S_RD_LO,
		S_RD_HI,
		S_MUL_A,
		S_MUL_B,
		S_MUL_C,
		S_ACC,
		S_SIGN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tli_mem.sv =====
// Breakpoint memory: one write port, one registered read port.
`default_nettype none

module tli_mem import tli_pkg::*; #(
	parameter int DEPTH = NUM_POINTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [ENTRY_W-1:0]       wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [ENTRY_W-1:0]       rd_data
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tli_div.sv =====
// Serial restoring divider: 64-bit magnitude by 32-bit magnitude, one bit a cycle.
`default_nettype none

module tli_div import tli_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*DATA_W-1:0]   num_mag,
	input  wire logic [DATA_W-1:0]     den_mag,
	output div_status_t                status
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] shf_q;
	logic [DATA_W-1:0] den_q;

	logic              num_ovf;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              step_bit;
	logic [DATA_W-1:0] step_rem;

	// Quotient needs more than 32 bits when the high half reaches the divisor
	assign num_ovf = (num_mag[2*DATA_W-1:DATA_W] >= den_mag);

	// One restoring step
	always_comb begin
		trial    = {rem_q, shf_q[DATA_W-1]};
		diff     = trial - {1'b0, den_q};
		step_bit = (trial >= {1'b0, den_q});
		step_rem = step_bit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (num_ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_mag[2*DATA_W-1:DATA_W];
			shf_q <= num_mag[DATA_W-1:0];
			den_q <= den_mag;
			ovf_q <= num_ovf;
		end else if (busy_q) begin
			rem_q <= step_rem;
			shf_q <= {shf_q[DATA_W-2:0], step_bit};
		end
	end

	assign status.done = done_q;
	assign status.ovf  = ovf_q;
	assign status.quo  = shf_q;

endmodule

`default_nettype wire

// ===== hw/rtl/table_linear_interpolator_top.sv =====
// Piecewise-linear interpolator over a breakpoint table, signed Q16.16.
//
// Requests arrive on in_valid/in_ready with an in_item_t payload. A load
// request (command 0) writes (x_value, y_value) into slot point_index in the
// cycle it is accepted and gives no result; slots at or above NUM_POINTS are
// ignored. A query request (command 1) binary-searches the table, reads the
// bracketing entries, forms both products on one multiplier and divides on a
// serial divider; one result follows on out_valid/out_ready.
// Each search round is one memory read plus one compare; the 32-step divider
// dominates the query time. A query whose quotient overflows skips the divider
// steps, and a query whose bracketing x values are equal finishes right after
// the reads. in_ready is high only when no query is in flight; a load leaves
// it high, and a new query is taken only once the previous one has left its
// last state.
// A result waiting on a stalled receiver sits in the output register; new
// requests are still taken, and the next query holds in its last state until
// the register frees up. Reset empties the output register and stops any
// query; table contents are undefined until loaded.
`default_nettype none

module table_linear_interpolator_top import tli_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	localparam int IDX_W = $clog2(NUM_POINTS);
	localparam logic [IDX_W-1:0] HI_INIT = IDX_W'(NUM_POINTS - 1);

	state_t state_q, state_n;

	// Search and datapath registers
	logic signed [DATA_W-1:0] qx_q;
	logic [IDX_W-1:0]         lo_q;
	logic [IDX_W-1:0]         hi_q;
	logic signed [DATA_W-1:0] xlo_q, ylo_q, yhi_q;
	logic signed [DATA_W:0]   dlo_q, dhi_q, den_q;
	logic signed [2*DATA_W:0] prod_q, acc_q;
	logic [2*DATA_W-1:0]      num_mag_q;
	logic [DATA_W-1:0]        den_mag_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] res_q;
	logic                     sat_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	// Memory ports
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ENTRY_W-1:0]  wr_data;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0]  rd_data;
	logic signed [DATA_W-1:0] rd_x, rd_y;

	logic                in_take;
	logic [31:0]         pidx_ext;
	logic                idx_ok;
	logic [IDX_W:0]      mid_sum;
	logic [IDX_W-1:0]    mid;
	logic                go_up;
	logic [IDX_W-1:0]    lo_n, hi_n;
	logic                more;
	logic                x_equal;
	logic                fin_take;

	logic signed [DATA_W:0]   mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic signed [2*DATA_W:0] mul_p;
	logic signed [2*DATA_W:0] acc_abs;
	logic signed [DATA_W:0]   den_abs;

	logic                     div_start;
	div_status_t              div_st;
	logic signed [DATA_W-1:0] div_res;
	logic                     div_sat;

	// Request side
	assign in_ready = (state_q == S_IDLE);
	assign in_take  = in_valid && in_ready;
	assign pidx_ext = 32'(in_data.point_index);
	assign idx_ok   = (pidx_ext < 32'(NUM_POINTS));
	assign wr_en    = in_take && (in_data.command == CMD_LOAD) && idx_ok;
	assign wr_addr  = pidx_ext[IDX_W-1:0];
	assign wr_data  = {in_data.x_value, in_data.y_value};

	tli_mem #(
		.DEPTH (NUM_POINTS)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_x = rd_data[ENTRY_W-1:DATA_W];
	assign rd_y = rd_data[DATA_W-1:0];

	// Search bounds update
	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[IDX_W:1];
		go_up   = (rd_x < qx_q);
		lo_n    = go_up ? mid : lo_q;
		hi_n    = go_up ? hi_q : mid;
		more    = ({1'b0, hi_n} > ({1'b0, lo_n} + (IDX_W+1)'(1)));
	end

	assign x_equal  = (rd_x == xlo_q);
	assign fin_take = !out_valid_q || out_ready;

	// Shared multiplier
	assign mul_p = mul_a * mul_b;

	// Magnitudes for the divider
	assign acc_abs = acc_q[2*DATA_W] ? -acc_q : acc_q;
	assign den_abs = den_q[DATA_W] ? -den_q : den_q;

	tli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (num_mag_q),
		.den_mag (den_mag_q),
		.status  (div_st)
	);

	// Sign, clamp and flag of the quotient
	always_comb begin
		div_sat = 1'b0;
		div_res = div_st.quo;
		if (div_st.ovf) begin
			div_sat = 1'b1;
			div_res = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			if (div_st.quo > NEG_LIMIT) begin
				div_sat = 1'b1;
				div_res = SAT_MIN;
			end else begin
				div_res = -div_st.quo;
			end
		end else if (div_st.quo[DATA_W-1]) begin
			div_sat = 1'b1;
			div_res = SAT_MAX;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_take && (in_data.command == CMD_QUERY)) state_n = S_ADDR;
			end
			S_ADDR:     state_n = S_CMP;
			S_CMP:      state_n = more ? S_ADDR : S_RD_LO;
			S_RD_LO:    state_n = S_RD_HI;
			S_RD_HI:    state_n = S_MUL_A;
			S_MUL_A:    state_n = x_equal ? S_FINISH : S_MUL_B;
			S_MUL_B:    state_n = S_MUL_C;
			S_MUL_C:    state_n = S_ACC;
			S_ACC:      state_n = S_SIGN;
			S_SIGN:     state_n = S_DIV_GO;
			S_DIV_GO:   state_n = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_st.done) state_n = S_FINISH;
			end
			S_FINISH: begin
				if (fin_take) state_n = S_IDLE;
			end
			default:    state_n = S_IDLE;
		endcase
	end

	// State outputs: memory reads, multiplier operands, divider start
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = lo_q;
		mul_a     = dlo_q;
		mul_b     = yhi_q;
		div_start = 1'b0;
		case (state_q)
			S_ADDR: begin
				rd_en   = 1'b1;
				rd_addr = mid;
			end
			S_RD_LO: begin
				rd_en   = 1'b1;
				rd_addr = lo_q;
			end
			S_RD_HI: begin
				rd_en   = 1'b1;
				rd_addr = hi_q;
			end
			S_MUL_C: begin
				mul_a = dhi_q;
				mul_b = ylo_q;
			end
			S_DIV_GO: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_take) begin
					qx_q <= in_data.x_value;
					lo_q <= '0;
					hi_q <= HI_INIT;
				end
			end
			S_CMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			S_RD_HI: begin
				xlo_q <= rd_x;
				ylo_q <= rd_y;
			end
			S_MUL_A: begin
				yhi_q <= rd_y;
				dlo_q <= {qx_q[DATA_W-1], qx_q} - {xlo_q[DATA_W-1], xlo_q};
				dhi_q <= {rd_x[DATA_W-1], rd_x} - {qx_q[DATA_W-1], qx_q};
				den_q <= {rd_x[DATA_W-1], rd_x} - {xlo_q[DATA_W-1], xlo_q};
				res_q <= ylo_q;
				sat_q <= 1'b0;
			end
			S_MUL_B: prod_q <= mul_p;
			S_MUL_C: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			S_ACC: acc_q <= acc_q + prod_q;
			S_SIGN: begin
				neg_q     <= acc_q[2*DATA_W] ^ den_q[DATA_W];
				num_mag_q <= acc_abs[2*DATA_W-1:0];
				den_mag_q <= den_abs[DATA_W-1:0];
			end
			S_DIV_WAIT: begin
				if (div_st.done) begin
					res_q <= div_res;
					sat_q <= div_sat;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FINISH) && fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && fin_take) begin
			out_q.y_result  <= res_q;
			out_q.saturated <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tli_checker.sv =====
// Port-level checker for the interpolator and its bind.
`default_nettype none
`include "table_linear_interpolator_top_defines.svh"

module tli_checker import tli_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// Stalled result must hold
	`TLI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed under stall")

	// A query occupies the block
	`TLI_ASSERT_NXT(a_query_busy, clk, arst_n, in_valid && in_ready && (in_data.command == CMD_QUERY), !in_ready, "ready stayed high after query request")

	// A load never blocks the next request
	`TLI_ASSERT_NXT(a_load_ready, clk, arst_n, in_valid && in_ready && (in_data.command == CMD_LOAD), in_ready, "ready dropped after load request")

	// Flagged results are clamp values
	`TLI_ASSERT_IMP(a_sat_clamp, clk, arst_n, out_valid && out_data.saturated, (out_data.y_result == SAT_MAX) || (out_data.y_result == SAT_MIN), "saturated result is not a clamp value")

endmodule

bind table_linear_interpolator_top tli_checker u_tli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== dv/tli_interp_check.sv =====
// Interpolator checker: tracks the breakpoint table, predicts query results, compares them.
`timescale 1ns / 1ps

module tli_interp_check import tli_pkg::*; #(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      run_done,
	output int        results_owed,
	output int        fail_count
);

	logic signed [DATA_W-1:0] bp_x [NUM_POINTS];
	logic signed [DATA_W-1:0] bp_y [NUM_POINTS];
	out_item_t                expected_y_q [$];
	out_item_t                want;
	bit                       leftover_checked = 1'b0;

	initial begin
		fail_count   = 0;
		results_owed = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("[%0t] interp check: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	// Binary search for the bracketing pair, then exact interpolation on raw Q16.16
	function automatic out_item_t interpolate_at(input logic signed [DATA_W-1:0] xq);
		int                  lo;
		int                  hi;
		int                  mid;
		logic signed [127:0] xv, xl, xh, yl, yh, num, den, quo;
		out_item_t           res;
		lo = 0;
		hi = NUM_POINTS - 1;
		do begin
			mid = (lo + hi) / 2;
			if (bp_x[mid] < xq) begin
				lo = mid;
			end else begin
				hi = mid;
			end
		end while (hi - lo > 1);
		xv = xq;
		xl = bp_x[lo];
		xh = bp_x[hi];
		yl = bp_y[lo];
		yh = bp_y[hi];
		res.saturated = 1'b0;
		if (xh == xl) begin
			// flat bracket: lower point's y as is
			res.y_result = bp_y[lo];
		end else begin
			num = (xv - xl) * yh + (xh - xv) * yl;
			den = xh - xl;
			quo = num / den;   // truncates toward zero, sign from both operands
			if (quo > SAT_MAX) begin
				res.y_result  = SAT_MAX;
				res.saturated = 1'b1;
			end else if (quo < SAT_MIN) begin
				res.y_result  = SAT_MIN;
				res.saturated = 1'b1;
			end else begin
				res.y_result = quo[DATA_W-1:0];
			end
		end
		return res;
	endfunction

	// Results are matched before requests so a same-edge query is never consumed early
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_y_q.size() == 0) begin
					flag_mismatch($sformatf("result %h with no query outstanding",
						out_data));
				end else begin
					want = expected_y_q.pop_front();
					if (out_data.y_result !== want.y_result) begin
						flag_mismatch($sformatf("y_result %h, expected %h",
							out_data.y_result, want.y_result));
					end
					if (out_data.saturated !== want.saturated) begin
						flag_mismatch($sformatf("saturated %b, expected %b (y %h)",
							out_data.saturated, want.saturated, want.y_result));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.command == CMD_LOAD) begin
					if (in_data.point_index < NUM_POINTS) begin
						bp_x[in_data.point_index] = in_data.x_value;
						bp_y[in_data.point_index] = in_data.y_value;
					end
				end else begin
					expected_y_q.push_back(interpolate_at(in_data.x_value));
				end
			end
			if (run_done && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_y_q.size() != 0) begin
					flag_mismatch($sformatf("%0d query results never arrived",
						expected_y_q.size()));
				end
			end
			results_owed = expected_y_q.size();
		end
	end

endmodule

// ===== dv/tb_table_linear_interpolator_top.sv =====
// Testbench top for the table interpolator: request stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_table_linear_interpolator_top;
	import tli_pkg::*;

	localparam int NUM_POINTS    = NUM_POINTS_DEF;
	localparam int ITEM_TARGET   = 1700;
	localparam int QUIET_TAIL    = 200;     // last requests go out with no stalls
	localparam int QUERY_LATENCY = 60;      // covers a query on a 32-entry table, plus margin
	localparam int CYCLE_LIMIT   = 600000;
	localparam int Q_ONE         = 65536;

	typedef enum int {
		TBL_WIDE,
		TBL_FINE,
		TBL_DUPLICATE,
		TBL_SCRAMBLED
	} table_shape_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      run_done  = 1'b0;
	int        results_owed;
	int        fail_count;
	bit        idle_on     = 1'b0;
	int        stall_left  = 0;
	int        items_sent  = 0;
	int        cycle_count = 0;

	// stimulus-side copy of the loaded x values, used to aim queries
	logic signed [DATA_W-1:0] tbl_x [NUM_POINTS];

	table_linear_interpolator_top #(.NUM_POINTS(NUM_POINTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	tli_interp_check #(.NUM_POINTS(NUM_POINTS)) u_interp_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.run_done     (run_done),
		.results_owed (results_owed),
		.fail_count   (fail_count)
	);

	always #10 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_table_linear_interpolator_top failed");
			$finish;
		end
	end

	// Receiver stalls in bursts, started at random while idle_on is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
		if (v > SAT_MAX) begin
			return SAT_MAX;
		end
		if (v < SAT_MIN) begin
			return SAT_MIN;
		end
		return v[DATA_W-1:0];
	endfunction

	// One request; valid stays up until the block takes it
	task automatic send_req(input logic cmd, input int idx,
		input logic signed [DATA_W-1:0] xv, input logic signed [DATA_W-1:0] yv);
		in_item_t item;
		int       gap;
		item.command     = cmd;
		item.point_index = idx[IN_IDX_W-1:0];
		item.x_value     = xv;
		item.y_value     = yv;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (cmd == CMD_LOAD && idx < NUM_POINTS) begin
			tbl_x[idx] = xv;
		end
		items_sent++;
	endtask

	initial begin
		table_shape_t             shape;
		longint                   step_max;
		longint                   span;
		longint                   xv;
		int unsigned              span_u;
		int unsigned              step_u;
		int                       n_query;
		int                       k;
		int                       pt;
		logic signed [DATA_W-1:0] yv;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: ramp from -15.0 to 15.0, first pair sharing x, steep last segment
		for (int i = 0; i < NUM_POINTS; i++) begin
			pt = (i == 0) ? -15 * Q_ONE : (i - 16) * Q_ONE;
			if (i == 30) begin
				yv = SAT_MIN;
			end else if (i == 31) begin
				yv = SAT_MAX;
			end else begin
				yv = ((i % 2) ? -i : i) * 3 * Q_ONE;
			end
			send_req(CMD_LOAD, i, pt, yv);
		end
		send_req(CMD_QUERY, 0, SAT_MIN, 0);                       // flat bracket below span
		send_req(CMD_QUERY, 31, -11 * Q_ONE, SAT_MAX);            // exact breakpoint
		send_req(CMD_QUERY, 5, -11 * Q_ONE + Q_ONE / 2, SAT_MIN); // midway
		send_req(CMD_QUERY, 0, 15 * Q_ONE, 0);                    // last breakpoint
		send_req(CMD_QUERY, 0, SAT_MAX, 0);                       // clamps high
		send_req(CMD_QUERY, 0, 14 * Q_ONE + 1, 0);
		// steep first segment for the low clamp and an exact minimum
		send_req(CMD_LOAD, 0, -17 * Q_ONE, SAT_MIN);
		send_req(CMD_LOAD, 1, -15 * Q_ONE, SAT_MAX);
		send_req(CMD_QUERY, 0, SAT_MIN, 0);                       // clamps low
		send_req(CMD_QUERY, 0, -17 * Q_ONE, 0);                   // exactly the minimum
		// last entry out of order: negative denominator
		send_req(CMD_LOAD, 31, 0, 12345);
		send_req(CMD_QUERY, 0, 15 * Q_ONE, 0);
		send_req(CMD_QUERY, 0, SAT_MAX, 0);
		send_req(CMD_QUERY, 0, 14 * Q_ONE + Q_ONE / 4, 0);

		// Random: a fresh table, then a batch of queries with occasional rewrites
		while (items_sent < ITEM_TARGET) begin
			idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			shape   = table_shape_t'($urandom_range(0, 3));
			case (shape)
				TBL_FINE:      step_max = 16;
				TBL_DUPLICATE: step_max = $urandom_range(1, 1 << 20);
				default:       step_max = 64'd1 << 27;
			endcase
			span   = 64'd4294967295 - 31 * step_max;
			span_u = span;
			step_u = step_max;
			xv     = $urandom_range(0, span_u);
			xv     = xv - 64'sd2147483648;
			for (int i = 0; i < NUM_POINTS; i++) begin
				if ($urandom_range(0, 1)) begin
					yv = $urandom;
				end else begin
					yv = $urandom_range(0, 1 << 21) - (1 << 20);
				end
				if (shape == TBL_SCRAMBLED) begin
					send_req(CMD_LOAD, i, $urandom, yv);
				end else begin
					send_req(CMD_LOAD, i, xv, yv);
					if (shape == TBL_DUPLICATE) begin
						xv = xv + ($urandom_range(0, 1) ? step_max : 0);
					end else begin
						xv = xv + $urandom_range(0, step_u);
					end
				end
			end

			n_query = $urandom_range(8, 24);
			for (int q = 0; q < n_query; q++) begin
				k = $urandom_range(0, NUM_POINTS - 2);
				if ($urandom_range(0, 9) == 0) begin
					send_req(CMD_LOAD, k, $urandom, $urandom);
				end else begin
					case ($urandom_range(0, 9))
						0: xv = $signed($urandom);
						1: xv = $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
						2, 3, 4: xv = tbl_x[k];
						5, 6: begin
							xv = tbl_x[k];
							xv = xv + $urandom_range(0, 64) - 32;
						end
						7: begin
							xv = tbl_x[k];
							xv = (xv + tbl_x[k + 1]) / 2;
						end
						8: begin
							xv = tbl_x[0];
							xv = xv - $urandom_range(0, 1 << 24);
						end
						default: begin
							xv = tbl_x[NUM_POINTS - 1];
							xv = xv + $urandom_range(0, 1 << 24);
						end
					endcase
					send_req(CMD_QUERY, $urandom_range(0, 31), clamp_q(xv), $urandom);
				end
			end
		end

		// Drain and verdict
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (QUERY_LATENCY) @(posedge clk);
		run_done <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_table_linear_interpolator_top passed");
		end else begin
			$display("tb_table_linear_interpolator_top failed");
		end
		$finish;
	end

endmodule
